// File: rtl/rpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ray / polygon crossing counter.
// No dependencies; imported by every module of the block.
package rpc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 2'd3;

  // Depth of the job queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;

  // Number of pipeline stages inside one edge test lane
  localparam int EDGE_STAGES = 4;

  // Control flags that travel with each vertex job
  typedef struct packed {
    logic has_edge;  // an edge from the previous vertex ends here
    logic last;      // closing edge is tested and the count is emitted
  } job_flags_t;

endpackage

// File: rtl/rpc_front.sv
`timescale 1ns / 1ps
// Front end: accepts vertex beats, tracks first and previous vertex,
// and turns each vertex into one edge-test job. Depends on rpc_pkg.
module rpc_front
  import rpc_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic                        last_vertex,
  input  logic                        q_full,
  output logic                        push,
  // {first_y, first_x, cur_y, cur_x, prev_y, prev_x}, prev_x lowest
  output logic [6*COORD_BITS-1:0]     job_coords,
  output job_flags_t                  job_flags
);

  logic signed [COORD_BITS-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [COORD_BITS-1:0] first_x_nxt, first_y_nxt;
  logic                         have_r, have_nxt;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // First vertex of a polygon also closes onto itself
  assign first_x_nxt = have_r ? first_x_r : vertex_x;
  assign first_y_nxt = have_r ? first_y_r : vertex_y;
  assign have_nxt    = !last_vertex;

  assign job_coords = {first_y_nxt, first_x_nxt, vertex_y, vertex_x, prev_y_r, prev_x_r};
  assign job_flags  = '{has_edge: have_r, last: last_vertex};

  // Vertex tracking; coordinates need no reset
  always_ff @(posedge clk) begin
    if (push) begin
      first_x_r <= first_x_nxt;
      first_y_r <= first_y_nxt;
      prev_x_r  <= vertex_x;
      prev_y_r  <= vertex_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (push) begin
      have_r <= have_nxt;
    end
  end

endmodule

// File: rtl/rpc_queue.sv
`timescale 1ns / 1ps
// Small job queue between front and back ends.
// Register file with read and write pointers. Depends on rpc_pkg.
module rpc_queue
  import rpc_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_full_not_empty : assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !empty)
    else $error("queue reports full and empty together");

  a_empty_ptrs : assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue empty with pointers apart");

  a_fill_up : assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop && !full) |=> (cnt_r == $past(cnt_r) + CNTW'(1)))
    else $error("queue fill level did not follow a push");
`endif

endmodule

// File: rtl/rpc_edge.sv
`timescale 1ns / 1ps
// One edge-test lane: four-stage pipeline of differences, products,
// cross products and the sign test. Depends on rpc_pkg.
module rpc_edge
  import rpc_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] sx,
  input  logic signed [COORD_BITS-1:0] sy,
  input  logic signed [COORD_BITS-1:0] ex,
  input  logic signed [COORD_BITS-1:0] ey,
  input  logic signed [COORD_BITS-1:0] ox,
  input  logic signed [COORD_BITS-1:0] oy,
  input  logic signed [COORD_BITS-1:0] dx,
  input  logic signed [COORD_BITS-1:0] dy,
  output logic                         hit
);

  localparam int DW = COORD_BITS + 1;  // coordinate differences
  localparam int PW = 2 * DW;          // exact products
  localparam int XW = PW + 1;          // cross products
  localparam int SW = XW + 1;          // sn - den

  logic signed [DW-1:0] dxe, dye;
  logic signed [DW-1:0] vx_r, vy_r, nx_r, ny_r;
  logic signed [PW-1:0] p_dv1_r, p_dv2_r, p_vn1_r, p_vn2_r, p_dn1_r, p_dn2_r;
  logic signed [XW-1:0] den_r, tn_r, sn_r;
  logic signed [SW-1:0] sm;
  logic                 hit_nxt, den_pos, sn_ge, sn_le, tn_ge, tn_le, sm_ge, sm_le;

  // Ray direction; the user must keep it stable while jobs are in flight, as the block does not enforce this
  assign dxe = DW'(dx);
  assign dye = DW'(dy);

  // Stage 1: edge vector v and offset n = origin - start
  always_ff @(posedge clk) begin
    if (en) begin
      vx_r <= DW'(ex) - DW'(sx);
      vy_r <= DW'(ey) - DW'(sy);
      nx_r <= DW'(ox) - DW'(sx);
      ny_r <= DW'(oy) - DW'(sy);
    end
  end

  // Stage 2: the six products
  always_ff @(posedge clk) begin
    if (en) begin
      p_dv1_r <= PW'(dxe) * PW'(vy_r);
      p_dv2_r <= PW'(dye) * PW'(vx_r);
      p_vn1_r <= PW'(vx_r) * PW'(ny_r);
      p_vn2_r <= PW'(vy_r) * PW'(nx_r);
      p_dn1_r <= PW'(dxe) * PW'(ny_r);
      p_dn2_r <= PW'(dye) * PW'(nx_r);
    end
  end

  // Stage 3: den = d x v, tn = v x n, sn = d x n
  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= XW'(p_dv1_r) - XW'(p_dv2_r);
      tn_r  <= XW'(p_vn1_r) - XW'(p_vn2_r);
      sn_r  <= XW'(p_dn1_r) - XW'(p_dn2_r);
    end
  end

  // Stage 4: s in [0,1] and t >= 0, tested by sign against den
  assign sm      = SW'(sn_r) - SW'(den_r);
  assign den_pos = !den_r[XW-1];
  assign sn_ge   = !sn_r[XW-1];
  assign sn_le   = sn_r[XW-1] || (sn_r == '0);
  assign tn_ge   = !tn_r[XW-1];
  assign tn_le   = tn_r[XW-1] || (tn_r == '0);
  assign sm_ge   = !sm[SW-1];
  assign sm_le   = sm[SW-1] || (sm == '0);

  always_comb begin
    if (den_r == '0) begin
      hit_nxt = 1'b0;
    end else if (den_pos) begin
      hit_nxt = sn_ge && sm_le && tn_ge;
    end else begin
      hit_nxt = sn_le && sm_ge && tn_le;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hit_nxt;
    end
  end

endmodule

// File: rtl/rpc_back.sv
`timescale 1ns / 1ps
// Back end: ray registers, an edge-test lane for each edge of a job, the saturating crossing
// counter and the result register. Depends on rpc_pkg and rpc_edge.
module rpc_back
  import rpc_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration writes
  input  logic                          cfg_wr,
  input  logic [CFG_IDX_W-1:0]          cfg_idx,
  input  logic [COORD_BITS-1:0]         cfg_wdata,
  // job queue read side
  input  logic                          q_empty,
  input  logic [6*COORD_BITS-1:0]       q_coords,
  input  job_flags_t                    q_flags,
  output logic                          pop,
  // result
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COUNT_BITS-1:0]         count
);

  localparam int CW = COORD_BITS;
  localparam int NS = EDGE_STAGES;

  logic signed [CW-1:0] origin_x_r, origin_y_r, dir_x_r, dir_y_r;
  logic signed [CW-1:0] prev_x, prev_y, cur_x, cur_y, first_x, first_y;
  logic                 stall, adv, hit_a, hit_b;
  logic [NS-1:0]        v_r;
  job_flags_t           fl_r [NS];
  logic [COUNT_BITS-1:0] count_r, count_nxt, sat;
  logic [COUNT_BITS:0]   sum;
  logic [1:0]            inc;
  logic                  out_valid_r, done;
  logic [COUNT_BITS-1:0] out_count_r;

  // Ray registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      dir_x_r    <= CW'(1);
      dir_y_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ORIGIN_X: origin_x_r <= cfg_wdata;
        REG_ORIGIN_Y: origin_y_r <= cfg_wdata;
        REG_DIR_X:    dir_x_r    <= cfg_wdata;
        REG_DIR_Y:    dir_y_r    <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // Whole pipeline holds while a finished count waits
  assign stall = out_valid_r && !out_ready;
  assign adv   = !stall;
  assign pop   = !q_empty && adv;

  assign prev_x  = q_coords[0*CW +: CW];
  assign prev_y  = q_coords[1*CW +: CW];
  assign cur_x   = q_coords[2*CW +: CW];
  assign cur_y   = q_coords[3*CW +: CW];
  assign first_x = q_coords[4*CW +: CW];
  assign first_y = q_coords[5*CW +: CW];

  // Lane A: previous -> current
  rpc_edge #(.COORD_BITS(COORD_BITS)) u_edge_a (
    .clk (clk), .en (adv),
    .sx (prev_x), .sy (prev_y), .ex (cur_x), .ey (cur_y),
    .ox (origin_x_r), .oy (origin_y_r), .dx (dir_x_r), .dy (dir_y_r),
    .hit (hit_a)
  );

  // Lane B: closing edge current -> first
  rpc_edge #(.COORD_BITS(COORD_BITS)) u_edge_b (
    .clk (clk), .en (adv),
    .sx (cur_x), .sy (cur_y), .ex (first_x), .ey (first_y),
    .ox (origin_x_r), .oy (origin_y_r), .dx (dir_x_r), .dy (dir_y_r),
    .hit (hit_b)
  );

  // Valid bits and flags alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fl_r[0] <= q_flags;
      for (int i = 1; i < NS; i++) begin
        fl_r[i] <= fl_r[i-1];
      end
    end
  end

  // Saturating add of up to two crossings
  assign inc  = {1'b0, hit_a && fl_r[NS-1].has_edge} + {1'b0, hit_b && fl_r[NS-1].last};
  assign sum  = {1'b0, count_r} + (COUNT_BITS+1)'(inc);
  assign sat  = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
  assign done = adv && v_r[NS-1];

  always_comb begin
    count_nxt = count_r;
    if (done) begin
      count_nxt = fl_r[NS-1].last ? '0 : sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done && fl_r[NS-1].last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && fl_r[NS-1].last) begin
      out_count_r <= sat;
    end
  end

  assign out_valid = out_valid_r;
  assign count     = out_count_r;

`ifndef SYNTH
  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> (v_r == $past(v_r)))
    else $error("pipeline moved while the result was stalled");

  a_last_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (done && fl_r[NS-1].last) |=> (out_valid_r && (count_r == '0)))
    else $error("last vertex did not emit and clear the count");

  a_no_pop_stalled : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !pop)
    else $error("job taken from queue during output stall");
`endif

endmodule

// File: rtl/ray_polygon_crossing_count.sv
`timescale 1ns / 1ps
// Top level of the ray / polygon crossing counter: front end, job queue
// and back end. Depends on rpc_pkg, rpc_front, rpc_queue and rpc_back.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_tvalid in_tready in_tdata in_tlast | vertex beats in
//   out     | out_tvalid out_tready out_tdata       | crossing count out
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data| ray register writes
//
// One vertex beat per cycle while in_tready is high; each vertex is one job
// that tests both its edges in two parallel four-stage lanes (one multiply
// stage); out_tvalid is set once the last vertex's job has left the lanes.
// A stalled result freezes the back end; the four-entry job queue keeps
// the front accepting until it fills, then in_tready drops.
// Reset (rst_n low, synchronous) sets origin (0,0), direction (1,0),
// count zero and no vertex seen; there is no clearing pass.
module ray_polygon_crossing_count
  import rpc_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 16,
  localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((COUNT_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // vertex input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // vertex_x, vertex_y, zero pad
  input  logic                  in_tlast,   // last_vertex
  // count output
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // crossing_count, zero pad
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);

  localparam int JOB_W = 6 * COORD_BITS + $bits(job_flags_t);

  logic                    push, pop, q_full, q_empty;
  logic [6*COORD_BITS-1:0] job_coords, q_coords;
  job_flags_t              job_flags, q_flags;
  logic [JOB_W-1:0]        q_rd;
  logic [COUNT_BITS-1:0]   count;

  assign cfg_ready = 1'b1;

  rpc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .vertex_x    (in_tdata[COORD_BITS-1:0]),
    .vertex_y    (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .last_vertex (in_tlast),
    .q_full      (q_full),
    .push        (push),
    .job_coords  (job_coords),
    .job_flags   (job_flags)
  );

  rpc_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data ({job_coords, job_flags}),
    .pop     (pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  assign q_coords = q_rd[JOB_W-1:$bits(job_flags_t)];
  assign q_flags  = q_rd[$bits(job_flags_t)-1:0];

  rpc_back #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .q_empty   (q_empty),
    .q_coords  (q_coords),
    .q_flags   (q_flags),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .count     (count)
  );

  assign out_tdata = OUT_W'(count);

endmodule
